// File: src/klrp_pkg.sv
// shared types, constants and character codes for the key layout record parser
package klrp_pkg;

    localparam int MAX_KEYS   = 512;
    localparam int FIELD_BITS = 16;
    localparam int OUT_BITS   = 16;
    localparam int CNT_W      = $clog2(MAX_KEYS + 1);
    localparam int IDX_W      = 9;
    localparam int NUM_ACC    = 6;
    localparam int ACC_SEL_W  = $clog2(NUM_ACC);

    localparam logic [ACC_SEL_W-1:0] ACC_KEY = ACC_SEL_W'(NUM_ACC - 1);

    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    typedef enum logic [9:0] {
        ST_LAYOUT     = 10'b00_0000_0001,
        ST_LEFT       = 10'b00_0000_0010,
        ST_TOP        = 10'b00_0000_0100,
        ST_RIGHT      = 10'b00_0000_1000,
        ST_BOTTOM     = 10'b00_0001_0000,
        ST_KEY        = 10'b00_0010_0000,
        ST_KEY_END    = 10'b00_0100_0000,
        ST_BRACE      = 10'b00_1000_0000,
        ST_BRACE_CHAR = 10'b01_0000_0000,
        ST_BRACE_END  = 10'b10_0000_0000
    } t_stage;

    typedef logic [FIELD_BITS-1:0] t_acc;

    typedef struct packed {
        logic                 in_record;
        t_stage               stage;
        logic                 digits_seen;
        t_acc [NUM_ACC-1:0]   acc;
        logic [CNT_W-1:0]     records_done;
    } t_state;

    typedef struct packed {
        logic [OUT_BITS-1:0]  layout_id;
        logic [OUT_BITS-1:0]  left_edge;
        logic [OUT_BITS-1:0]  top_edge;
        logic [OUT_BITS-1:0]  right_edge;
        logic [OUT_BITS-1:0]  bottom_edge;
        logic [OUT_BITS-1:0]  key_code;
        logic                 well_formed;
        logic [IDX_W-1:0]     record_index;
        logic                 overflow;
    } t_result;

endpackage

// File: src/klrp_step.sv
// next-state and record result logic for one byte of the layout text
module klrp_step (
    input  logic [7:0]       i_byte_value,
    input  logic             i_last_byte,
    input  klrp_pkg::t_state i_state,
    output klrp_pkg::t_state o_state,
    output logic             o_emit,
    output klrp_pkg::t_result o_result
);
    import klrp_pkg::*;

    t_state                 s;
    logic                   is_digit;
    logic                   above_space;
    logic                   close_rec;
    logic                   good;
    logic [ACC_SEL_W-1:0]   sel;
    t_acc                   mac;
    logic [7:0]             sep;
    logic                   full;

    assign is_digit    = i_byte_value inside {[CH_ZERO:CH_NINE]};
    assign above_space = i_byte_value > CH_SPACE;

    always_comb begin
        case (i_state.stage)
            ST_LAYOUT: sel = ACC_SEL_W'(0);
            ST_LEFT:   sel = ACC_SEL_W'(1);
            ST_TOP:    sel = ACC_SEL_W'(2);
            ST_RIGHT:  sel = ACC_SEL_W'(3);
            ST_BOTTOM: sel = ACC_SEL_W'(4);
            default:   sel = ACC_KEY;
        endcase
    end

    // a freshly opened record starts with zero accumulators
    assign mac = (!i_state.in_record) ? FIELD_BITS'(i_byte_value - CH_ZERO)
               : FIELD_BITS'(32'(i_state.acc[sel]) * 32'd10
                             + 32'(i_byte_value - CH_ZERO));

    assign sep = (i_state.stage == ST_BOTTOM) ? CH_COLON : CH_COMMA;

    always_comb begin
        s         = i_state;
        close_rec = 1'b0;
        good      = 1'b0;
        if (!i_state.in_record && above_space) begin
            s.in_record   = 1'b1;
            s.stage       = ST_LAYOUT;
            s.digits_seen = 1'b0;
            s.acc         = '0;
        end
        if (s.in_record) begin
            case (s.stage)
                ST_LAYOUT, ST_LEFT, ST_TOP, ST_RIGHT, ST_BOTTOM: begin
                    if (is_digit) begin
                        s.acc[sel]    = mac;
                        s.digits_seen = 1'b1;
                    end else if (i_byte_value == sep && s.digits_seen) begin
                        s.digits_seen = 1'b0;
                        case (s.stage)
                            ST_LAYOUT: s.stage = ST_LEFT;
                            ST_LEFT:   s.stage = ST_TOP;
                            ST_TOP:    s.stage = ST_RIGHT;
                            ST_RIGHT:  s.stage = ST_BOTTOM;
                            default:   s.stage = ST_KEY;
                        endcase
                    end else if (above_space || s.digits_seen) begin
                        close_rec = 1'b1;
                    end
                end
                ST_KEY: begin
                    if (i_byte_value == CH_LBRACE) begin
                        s.stage = ST_BRACE;
                    end else if (i_byte_value == CH_SEMI) begin
                        close_rec = 1'b1;
                    end else if (above_space) begin
                        s.acc[ACC_KEY] = FIELD_BITS'(i_byte_value);
                        s.stage        = ST_KEY_END;
                    end
                end
                ST_KEY_END, ST_BRACE_END: begin
                    if (i_byte_value == CH_SEMI) begin
                        good      = 1'b1;
                        close_rec = 1'b1;
                    end else if (above_space) begin
                        close_rec = 1'b1;
                    end
                end
                ST_BRACE: begin
                    if (is_digit) begin
                        s.acc[ACC_KEY] = mac;
                        s.digits_seen  = 1'b1;
                    end else if (i_byte_value == CH_RBRACE && s.digits_seen) begin
                        s.digits_seen = 1'b0;
                        s.stage       = ST_BRACE_END;
                    end else if (!s.digits_seen && (i_byte_value == CH_LBRACE
                                 || i_byte_value == CH_RBRACE
                                 || i_byte_value == CH_SEMI)) begin
                        s.acc[ACC_KEY] = FIELD_BITS'(i_byte_value);
                        s.stage        = ST_BRACE_CHAR;
                    end else if (above_space || s.digits_seen) begin
                        close_rec = 1'b1;
                    end
                end
                ST_BRACE_CHAR: begin
                    if (i_byte_value == CH_RBRACE) begin
                        s.stage = ST_BRACE_END;
                    end else if (above_space) begin
                        close_rec = 1'b1;
                    end
                end
                default: close_rec = 1'b1;
            endcase
        end
    end

    assign o_emit = s.in_record && (close_rec || i_last_byte);
    assign full   = i_state.records_done >= CNT_W'(MAX_KEYS);

    always_comb begin
        o_result.layout_id    = OUT_BITS'(s.acc[0]);
        o_result.left_edge    = OUT_BITS'(s.acc[1]);
        o_result.top_edge     = OUT_BITS'(s.acc[2]);
        o_result.right_edge   = OUT_BITS'(s.acc[3]);
        o_result.bottom_edge  = OUT_BITS'(s.acc[4]);
        o_result.key_code     = OUT_BITS'(s.acc[ACC_KEY]);
        o_result.well_formed  = good;
        o_result.record_index = full ? '0 : IDX_W'(i_state.records_done);
        o_result.overflow     = full;
    end

    always_comb begin
        o_state = s;
        if (o_emit) begin
            o_state.in_record   = 1'b0;
            o_state.stage       = ST_LAYOUT;
            o_state.digits_seen = 1'b0;
            if (!full) begin
                o_state.records_done = i_state.records_done + CNT_W'(1);
            end
        end
        if (i_last_byte) begin
            o_state.in_record    = 1'b0;
            o_state.stage        = ST_LAYOUT;
            o_state.digits_seen  = 1'b0;
            o_state.records_done = '0;
        end
    end

endmodule

// File: src/key_layout_record_parser.sv
// key layout record parser: byte stream in, one record beat per closed record out
// a record is registered and presented on the outputs in the cycle after its closing beat
// throughput: one byte beat per cycle, set by the single parse-and-accumulate pass
// byte beats stall only while a record beat waits and the receiver is not ready
// reset: synchronous active-low, clears parser state, record count and output valid
module key_layout_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_layout_id,
    output logic [15:0] o_left_edge,
    output logic [15:0] o_top_edge,
    output logic [15:0] o_right_edge,
    output logic [15:0] o_bottom_edge,
    output logic [15:0] o_key_code,
    output logic        o_well_formed,
    output logic [8:0]  o_record_index,
    output logic        o_overflow
);
    import klrp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    n_emit;
    logic    in_beat;

    klrp_step u_step (
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_emit       (n_emit),
        .o_result     (n_out)
    );

    assign o_ready = !r_out_valid || i_ready;
    assign in_beat = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.in_record    <= 1'b0;
            r_state.stage        <= ST_LAYOUT;
            r_state.digits_seen  <= 1'b0;
            r_state.acc          <= '0;
            r_state.records_done <= '0;
            r_out_valid          <= 1'b0;
        end else begin
            if (in_beat) begin
                r_state.in_record    <= n_state.in_record;
                r_state.stage        <= n_state.stage;
                r_state.digits_seen  <= n_state.digits_seen;
                r_state.acc          <= n_state.acc;
                r_state.records_done <= n_state.records_done;
            end
            if (in_beat && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_beat && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_layout_id    = r_out.layout_id;
    assign o_left_edge    = r_out.left_edge;
    assign o_top_edge     = r_out.top_edge;
    assign o_right_edge   = r_out.right_edge;
    assign o_bottom_edge  = r_out.bottom_edge;
    assign o_key_code     = r_out.key_code;
    assign o_well_formed  = r_out.well_formed;
    assign o_record_index = r_out.record_index;
    assign o_overflow     = r_out.overflow;

endmodule
